/* design/set_assoc_cache_lfu_assert.svh */
// Assertion macros used by the cache core RTL. They expect clk and rst_n in scope.
`ifndef SET_ASSOC_CACHE_LFU_ASSERT_SVH
`define SET_ASSOC_CACHE_LFU_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sacl_pkg.sv */
package sacl_pkg;

  localparam int ADDR_W   = 32;  // input address port width
  localparam int TOTAL_W  = 32;  // hit total width
  localparam int CDIV_LAT = 2;   // register stages in sacl_cdiv

  typedef enum logic {
    CLR_ST_SWEEP,
    CLR_ST_RUN
  } clr_state_t;

endpackage

/* design/sacl_cdiv.sv */
// quotient and remainder by a constant: x * floor(2^S / D), then one correction step
module sacl_cdiv #(
  parameter int XW = 32,
  parameter int D  = 1
) (
  input  logic                                   clk,
  input  logic [XW-1:0]                          x_i,
  output logic [XW-1:0]                          q_o,
  output logic [((D > 1) ? $clog2(D) : 1)-1:0]   r_o
);

  localparam int CW = $clog2(D);
  localparam int RW = (D > 1) ? CW : 1;
  localparam int EW = RW + 1;
  localparam int S  = XW + CW;
  localparam int MW = XW + 1;
  localparam int PW = XW + MW;
  localparam logic [S:0]    POW   = {1'b1, {S{1'b0}}};
  localparam logic [S:0]    MFULL = POW / (S+1)'(D);
  localparam logic [MW-1:0] MUL   = MFULL[MW-1:0];

  logic [PW-1:0] prod_r;
  logic [XW-1:0] x1_r;
  logic [XW-1:0] qe;
  logic [EW-1:0] qd_lo;
  logic [EW-1:0] rr;
  logic          cor;
  logic [XW-1:0] q_r;
  logic [RW-1:0] r_r;

  always_ff @(posedge clk) begin
    prod_r <= {{MW{1'b0}}, x_i} * {{XW{1'b0}}, MUL};
    x1_r   <= x_i;
  end

  assign qe    = XW'(prod_r >> S);
  assign qd_lo = EW'(qe[EW-1:0] * EW'(D));
  assign rr    = x1_r[EW-1:0] - qd_lo;
  assign cor   = (rr >= EW'(D));

  always_ff @(posedge clk) begin
    q_r <= qe + XW'(cor);
    r_r <= cor ? RW'(rr - EW'(D)) : RW'(rr);
  end

  assign q_o = q_r;
  assign r_o = r_r;

endmodule

/* design/sacl_ways.sv */
// hit detect, LFU victim tree and row update for one set
module sacl_ways #(
  parameter int WAYS = 4,
  parameter int TW   = 20,
  parameter int CB   = 16
) (
  input  logic [WAYS-1:0]         vld_i,
  input  logic [WAYS-1:0][TW-1:0] tag_i,
  input  logic [WAYS-1:0][CB-1:0] cnt_i,
  input  logic [TW-1:0]           key_i,
  output logic                    hit_o,
  output logic [WAYS-1:0]         vld_o,
  output logic [WAYS-1:0][TW-1:0] tag_o,
  output logic [WAYS-1:0][CB-1:0] cnt_o
);

  localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int P   = 1 << $clog2(WAYS);
  localparam int NN  = 2 * P - 1;

  logic [WAYS-1:0] match;
  logic [WIW-1:0]  hit_way;
  logic [WIW-1:0]  victim;
  logic [CB-1:0]   node_c [NN];
  logic [WIW-1:0]  node_i [NN];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vld_i[w] && (tag_i[w] == key_i);
    end
  end

  always_comb begin
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WIW'(w);
    end
  end

  // min tree, left wins ties; invalid ways count as zero, padding as max
  always_comb begin
    for (int j = 0; j < P; j++) begin
      if (j < WAYS) begin
        node_c[P-1+j] = vld_i[j] ? cnt_i[j] : '0;
        node_i[P-1+j] = WIW'(j);
      end else begin
        node_c[P-1+j] = '1;
        node_i[P-1+j] = '0;
      end
    end
    for (int n = P - 2; n >= 0; n--) begin
      if (node_c[2*n+2] < node_c[2*n+1]) begin
        node_c[n] = node_c[2*n+2];
        node_i[n] = node_i[2*n+2];
      end else begin
        node_c[n] = node_c[2*n+1];
        node_i[n] = node_i[2*n+1];
      end
    end
  end

  assign victim = node_i[0];
  assign hit_o  = |match;

  always_comb begin
    vld_o = vld_i;
    tag_o = tag_i;
    cnt_o = cnt_i;
    if (hit_o) begin
      if (cnt_i[hit_way] != '1) cnt_o[hit_way] = cnt_i[hit_way] + 1'b1;
    end else begin
      vld_o[victim] = 1'b1;
      tag_o[victim] = key_i;
      cnt_o[victim] = CB'(1);
    end
  end

endmodule

/* design/sacl_core.sv */
`include "set_assoc_cache_lfu_assert.svh"

// valid-bit sweep, set memories, read-modify-write with forwarding, hit total and result beat
module sacl_core
  import sacl_pkg::*;
#(
  parameter int WAYS = 4,
  parameter int SETS = 128,
  parameter int TW   = 20,
  parameter int CB   = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    req_vld_i,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] req_set_i,
  input  logic [TW-1:0]                           req_tag_i,
  output logic                                    busy_o,
  output logic                                    out_valid_o,
  output logic                                    out_hit_o,
  output logic [TOTAL_W-1:0]                      out_hit_total_o
);

  localparam int SIW = (SETS > 1) ? $clog2(SETS) : 1;

  clr_state_t     state_r;
  clr_state_t     state_nxt;
  logic [SIW-1:0] clr_idx_r;
  logic           clr_last;
  logic           clr_we;

  logic [WAYS-1:0]         vld_mem [SETS];
  logic [WAYS-1:0][TW-1:0] tag_mem [SETS];
  logic [WAYS-1:0][CB-1:0] cnt_mem [SETS];

  logic [WAYS-1:0]         rd_vld_r;
  logic [WAYS-1:0][TW-1:0] rd_tag_r;
  logic [WAYS-1:0][CB-1:0] rd_cnt_r;

  logic                    e_vld_r;
  logic [SIW-1:0]          e_set_r;
  logic [TW-1:0]           e_tag_r;
  logic                    e_hit;

  logic                    fw_r;
  logic [SIW-1:0]          fw_set_r;
  logic [WAYS-1:0]         fw_vld_r;
  logic [WAYS-1:0][TW-1:0] fw_tag_r;
  logic [WAYS-1:0][CB-1:0] fw_cnt_r;
  logic                    use_fw;

  logic [WAYS-1:0]         cur_vld;
  logic [WAYS-1:0][TW-1:0] cur_tag;
  logic [WAYS-1:0][CB-1:0] cur_cnt;
  logic [WAYS-1:0]         new_vld;
  logic [WAYS-1:0][TW-1:0] new_tag;
  logic [WAYS-1:0][CB-1:0] new_cnt;

  logic [TOTAL_W-1:0]      hit_cnt_r;
  logic [TOTAL_W-1:0]      hit_cnt_nxt;
  logic                    out_valid_r;
  logic                    out_hit_r;

  // valid-bit sweep after reset
  assign clr_last = (clr_idx_r == SIW'(SETS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CLR_ST_SWEEP: if (clr_last) state_nxt = CLR_ST_RUN;
      CLR_ST_RUN:   state_nxt = CLR_ST_RUN;
    endcase
  end

  always_comb begin
    unique case (state_r)
      CLR_ST_SWEEP: begin
        clr_we = 1'b1;
        busy_o = 1'b1;
      end
      CLR_ST_RUN: begin
        clr_we = 1'b0;
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CLR_ST_SWEEP;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_we && !clr_last) clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (req_vld_i) begin
      rd_vld_r <= vld_mem[req_set_i];
      rd_tag_r <= tag_mem[req_set_i];
      rd_cnt_r <= cnt_mem[req_set_i];
    end
  end

  always_ff @(posedge clk) begin
    priority if (clr_we) begin
      vld_mem[clr_idx_r] <= '0;
    end else if (e_vld_r) begin
      vld_mem[e_set_r] <= new_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (e_vld_r) begin
      tag_mem[e_set_r] <= new_tag;
      cnt_mem[e_set_r] <= new_cnt;
    end
  end

  // update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      fw_r    <= 1'b0;
    end else begin
      e_vld_r <= req_vld_i;
      fw_r    <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e_set_r  <= req_set_i;
    e_tag_r  <= req_tag_i;
    fw_set_r <= e_set_r;
    fw_vld_r <= new_vld;
    fw_tag_r <= new_tag;
    fw_cnt_r <= new_cnt;
  end

  // previous beat wrote this set on the edge that captured our read
  assign use_fw  = fw_r && (fw_set_r == e_set_r);
  assign cur_vld = use_fw ? fw_vld_r : rd_vld_r;
  assign cur_tag = use_fw ? fw_tag_r : rd_tag_r;
  assign cur_cnt = use_fw ? fw_cnt_r : rd_cnt_r;

  sacl_ways #(
    .WAYS (WAYS),
    .TW   (TW),
    .CB   (CB)
  ) u_ways (
    .vld_i (cur_vld),
    .tag_i (cur_tag),
    .cnt_i (cur_cnt),
    .key_i (e_tag_r),
    .hit_o (e_hit),
    .vld_o (new_vld),
    .tag_o (new_tag),
    .cnt_o (new_cnt)
  );

  assign hit_cnt_nxt = (e_vld_r && e_hit && (hit_cnt_r != '1)) ? hit_cnt_r + 1'b1
                                                               : hit_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= e_hit;
  end

  assign out_valid_o     = out_valid_r;
  assign out_hit_o       = out_hit_r;
  assign out_hit_total_o = hit_cnt_r;

  `SACL_ASSERT_NEXT(a_hit_inc, e_vld_r && e_hit && (hit_cnt_r != '1), hit_cnt_r == $past(hit_cnt_r) + 1'b1, "hit total did not advance on hit")
  `SACL_ASSERT_NEXT(a_miss_hold, e_vld_r && !e_hit, hit_cnt_r == $past(hit_cnt_r), "hit total moved on miss")
  `SACL_ASSERT_SAME(a_fill_free, e_vld_r && !e_hit && (cur_vld != '1), $countones(new_vld) == $countones(cur_vld) + 1, "miss did not fill a free way")
  `SACL_ASSERT_NEXT(a_sweep_idle, busy_o, !e_vld_r, "lookup during valid sweep")
  `SACL_ASSERT_SAME(a_hit_total, out_valid_r && out_hit_r, hit_cnt_r != '0, "hit beat with zero total")

endmodule

/* design/set_assoc_cache_lfu.sv */
// Set-associative hit/miss tracker with LFU replacement. An address beat is taken on a clock
// edge with start high and busy low, one per cycle at full rate. Each beat gives exactly one
// result on out_hit / out_hit_total, flagged by out_valid for a single cycle; results come in
// order and the receiver cannot stall them, so it must take every result on the cycle it
// appears. Each beat passes the address register, two constant dividers (line address, then
// set index; two stages each), the registered set read, the update stage and the output
// register. Rate is one beat per cycle: each beat does a single read-modify-write of its set,
// and a beat to the same set as the one just before it takes the updated set by forwarding.
// After reset busy stays high while the valid bits of all TOTAL_LINES / WAYS sets (128 by
// default) are swept clear; start is ignored during that time.
module set_assoc_cache_lfu
  import sacl_pkg::*;
#(
  parameter int WAYS        = 4,
  parameter int TOTAL_LINES = 512,
  parameter int LINE_BYTES  = 32,
  parameter int COUNT_BITS  = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ADDR_W-1:0]  in_address,
  output logic               out_valid,
  output logic               out_hit,
  output logic [TOTAL_W-1:0] out_hit_total
);

  localparam int SETS_RAW = TOTAL_LINES / WAYS;
  localparam int SETS     = (SETS_RAW > 0) ? SETS_RAW : 1;
  localparam int SIW      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AB       = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int SHIFT    = ($clog2(SETS + 1) - 1) + ($clog2(LINE_BYTES + 1) - 1);
  localparam int TW       = (AB > SHIFT) ? AB - SHIFT : 1;
  localparam int DL       = 2 * CDIV_LAT;
  localparam logic [ADDR_W:0]   AMASK_W = ({{ADDR_W{1'b0}}, 1'b1} << AB) - (ADDR_W+1)'(1);
  localparam logic [ADDR_W-1:0] AMASK   = AMASK_W[ADDR_W-1:0];

  logic                accept;
  logic                s0_vld_r;
  logic [ADDR_W-1:0]   s0_addr_r;
  logic [DL-1:0]       vld_pipe_r;
  logic [TW-1:0]       tag_pipe_r [DL];
  logic [ADDR_W-1:0]   line_addr;
  logic [SIW-1:0]      set_idx;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r   <= 1'b0;
      vld_pipe_r <= '0;
    end else begin
      s0_vld_r   <= accept;
      vld_pipe_r <= {vld_pipe_r[DL-2:0], s0_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s0_addr_r <= in_address & AMASK;
    tag_pipe_r[0] <= TW'(s0_addr_r >> SHIFT);
    for (int k = 1; k < DL; k++) begin
      tag_pipe_r[k] <= tag_pipe_r[k-1];
    end
  end

  sacl_cdiv #(
    .XW (ADDR_W),
    .D  (LINE_BYTES)
  ) u_line_div (
    .clk (clk),
    .x_i (s0_addr_r),
    .q_o (line_addr),
    .r_o ()
  );

  sacl_cdiv #(
    .XW (ADDR_W),
    .D  (SETS)
  ) u_set_div (
    .clk (clk),
    .x_i (line_addr),
    .q_o (),
    .r_o (set_idx)
  );

  sacl_core #(
    .WAYS (WAYS),
    .SETS (SETS),
    .TW   (TW),
    .CB   (COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_vld_i       (vld_pipe_r[DL-1]),
    .req_set_i       (set_idx),
    .req_tag_i       (tag_pipe_r[DL-1]),
    .busy_o          (busy),
    .out_valid_o     (out_valid),
    .out_hit_o       (out_hit),
    .out_hit_total_o (out_hit_total)
  );

endmodule
